// File: sv/tccs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text console package
// Shared screen geometry, field widths, command codes, state encoding and
// address helpers for the text console engine.
// ----------------------------------------------------------------------------
package tccs_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);

    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CELL_W = 16;

    localparam int IN_BITS  = CMD_W + CHAR_W + ROW_W + COL_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = CELL_W + ROW_W + COL_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
    localparam logic [7:0]        ATTR_RESET   = 8'h07;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_BLANK
    } t_state;

    // Logical row to physical row, given the scroll offset.
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                  input logic [ROW_W-1:0] base);
        logic [ROW_W:0] sum;
        sum = {1'b0, row} + {1'b0, base};
        if (sum >= (ROW_W + 1)'(ROWS)) begin
            sum = sum - (ROW_W + 1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] row_addr(input logic [ROW_W-1:0] prow);
        return ADDR_W'(prow) * ADDR_W'(COLS);
    endfunction

endpackage
`default_nettype wire

// File: sv/text_console_cursor_scroll.sv
`default_nettype none
// Puts, clears and out-of-range reads answer in the cycle after accept; screen
// reads pass the registered memory port, then the output register. Throughput:
// one put per cycle unless the output stalls; a scrolling put blocks input while
// the single write port blanks the new bottom row, and a clear until every cell
// is written. Reset: synchronous; a clearing pass writes every cell to 0x0720
// before the first word is accepted. Scrolling moves a row offset, not the data.
// ----------------------------------------------------------------------------
// Text console with cursor and scroll
// Keeps an 80x25 screen of 16-bit cells in one memory and a cursor; handles
// put, backspace, newline, scroll, clear and cell read commands.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [7:0]                  i_cfg_wdata,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    // [1:0] command, [9:2] char_code, [14:10] read_row, [21:15] read_col
    input  wire logic [tccs_pkg::IN_W-1:0]   i_s_tdata,
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    // [15:0] cell_word, [20:16] cursor_row, [27:21] cursor_col
    output logic [tccs_pkg::OUT_W-1:0]       o_m_tdata
);
    import tccs_pkg::*;

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] r_rd_data;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_sweep;
    logic [CELL_W-1:0] r_fill;
    logic [7:0]        r_text_color;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_base;
    logic [ROW_W-1:0]  r_blank_row;
    logic              r_out_valid;
    logic [CELL_W-1:0] r_out_word;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;

    t_cmd              in_cmd;
    logic [CHAR_W-1:0] in_char;
    logic [ROW_W-1:0]  in_rrow;
    logic [COL_W-1:0]  in_rcol;
    logic              acc;
    logic              rd_in_range;
    logic              scroll;
    logic              put_we;
    logic [ADDR_W-1:0] put_addr;
    logic [CELL_W-1:0] put_data;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [ADDR_W-1:0] cur_row_addr;
    logic              sweep_last;

    assign in_cmd  = t_cmd'(i_s_tdata[CMD_W-1:0]);
    assign in_char = i_s_tdata[CMD_W +: CHAR_W];
    assign in_rrow = i_s_tdata[CMD_W + CHAR_W +: ROW_W];
    assign in_rcol = i_s_tdata[CMD_W + CHAR_W + ROW_W +: COL_W];

    assign o_s_tready  = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
    assign acc         = i_s_tvalid && o_s_tready;
    assign rd_in_range = ({1'b0, in_rrow} < (ROW_W + 1)'(ROWS))
                      && ({1'b0, in_rcol} < (COL_W + 1)'(COLS));
    assign cur_row_addr = row_addr(phys_row(r_row, r_base));
    assign mem_raddr    = row_addr(phys_row(in_rrow, r_base)) + ADDR_W'(in_rcol);

    // Cursor movement and the cell write of a put command.
    always_comb begin
        n_row    = r_row;
        n_col    = r_col;
        scroll   = 1'b0;
        put_we   = 1'b0;
        put_addr = cur_row_addr + ADDR_W'(r_col);
        put_data = {r_text_color, in_char};
        if (in_cmd == CMD_PUT) begin
            if (in_char == CH_BACKSPACE) begin
                if (r_col != '0) begin
                    n_col    = r_col - 1'b1;
                    put_we   = 1'b1;
                    put_addr = cur_row_addr + ADDR_W'(r_col - 1'b1);
                    put_data = {r_text_color, CH_BLANK};
                end
            end else if (in_char == CH_NEWLINE) begin
                n_col = '0;
                if (r_row == ROW_W'(ROWS - 1)) begin
                    scroll = 1'b1;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end else begin
                put_we = 1'b1;
                if (r_col == COL_W'(COLS - 1)) begin
                    n_col = '0;
                    if (r_row == ROW_W'(ROWS - 1)) begin
                        scroll = 1'b1;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
        end else if (in_cmd == CMD_CLEAR) begin
            n_row = '0;
            n_col = '0;
        end
    end

    assign sweep_last = (r_state == ST_CLEAR) ? (r_sweep == ADDR_W'(CELLS - 1))
                                              : (r_sweep == ADDR_W'(COLS - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (sweep_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (acc) begin
                    if (in_cmd == CMD_CLEAR) begin
                        n_state = ST_CLEAR;
                    end else if (in_cmd == CMD_READ && rd_in_range) begin
                        n_state = ST_READ;
                    end else if (scroll) begin
                        n_state = ST_BLANK;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            ST_BLANK: begin
                if (sweep_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Memory write port selection.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = put_addr;
        mem_wdata = put_data;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_sweep;
                mem_wdata = r_fill;
            end
            ST_BLANK: begin
                mem_we    = 1'b1;
                mem_waddr = row_addr(r_blank_row) + r_sweep;
                mem_wdata = r_fill;
            end
            ST_IDLE: begin
                mem_we = acc && put_we;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_sweep      <= '0;
            r_fill       <= {ATTR_RESET, CH_BLANK};
            r_text_color <= ATTR_RESET;
            r_row        <= '0;
            r_col        <= '0;
            r_base       <= '0;
            r_blank_row  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_text_color <= i_cfg_wdata;
            end
            if (r_state == ST_CLEAR || r_state == ST_BLANK) begin
                r_sweep <= r_sweep + 1'b1;
            end
            if (acc) begin
                r_sweep <= '0;
                r_fill  <= {r_text_color, CH_BLANK};
                r_col   <= n_col;
                if (in_cmd == CMD_CLEAR) begin
                    r_row  <= '0;
                    r_base <= '0;
                end else if (scroll) begin
                    r_row       <= ROW_W'(ROWS - 1);
                    r_blank_row <= r_base;
                    r_base      <= (r_base == ROW_W'(ROWS - 1)) ? '0 : r_base + 1'b1;
                end else begin
                    r_row <= n_row;
                end
            end
            if (acc && !(in_cmd == CMD_READ && rd_in_range)) begin
                r_out_valid <= 1'b1;
            end else if (r_state == ST_READ) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_out_word <= '0;
            r_out_row  <= scroll ? ROW_W'(ROWS - 1) : n_row;
            r_out_col  <= n_col;
        end else if (r_state == ST_READ) begin
            r_out_word <= r_rd_data;
            r_out_row  <= r_row;
            r_out_col  <= r_col;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_W - OUT_BITS)'(0), r_out_col, r_out_row, r_out_word};

endmodule
`default_nettype wire
